### hdl/esd_pkg.sv
package esd_pkg;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_HEX   = 2'd2,
        MODE_OCT   = 2'd3
    } mode_t;

    localparam int MaxResults = 3;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_SEVEN     = 8'h37;
    localparam logic [7:0] CHAR_NINE      = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A   = 8'd97;
    localparam logic [7:0] CHAR_LOWER_F   = 8'd102;
    localparam logic [7:0] CHAR_UPPER_A   = 8'd65;
    localparam logic [7:0] CHAR_UPPER_F   = 8'd70;
    localparam logic [7:0] CHAR_A         = 8'h61;
    localparam logic [7:0] CHAR_B         = 8'h62;
    localparam logic [7:0] CHAR_F         = 8'h66;
    localparam logic [7:0] CHAR_N         = 8'h6E;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CHAR_V         = 8'h76;
    localparam logic [7:0] CHAR_X         = 8'h78;

    localparam logic [7:0] CODE_BEL = 8'h07;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_HT  = 8'h09;
    localparam logic [7:0] CODE_VT  = 8'h0B;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_value(input logic [7:0] c);
        hex_digit_t d;
        logic [7:0] t;
        d = '{valid: 1'b0, value: 4'd0};
        t = 8'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            t = c - CHAR_ZERO;
            d = '{valid: 1'b1, value: t[3:0]};
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
            t = c - CHAR_LOWER_A + 8'd10;
            d = '{valid: 1'b1, value: t[3:0]};
        end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            t = c - CHAR_UPPER_A + 8'd10;
            d = '{valid: 1'b1, value: t[3:0]};
        end
        return d;
    endfunction

endpackage

### hdl/escape_sequence_decoder.sv
// The first result beat is valid in the cycle after the input beat is accepted.
// Throughput: one input beat per cycle while each beat yields at most one result
// and m_ready is high; a beat that yields several results (up to 3) stalls the
// input while the result buffer drains them, one beat per cycle while m_ready is high.
// Reset (synchronous, active low aresetn): plain text mode, no results pending.
module escape_sequence_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last,
    output logic       m_string_end
);

    esd_pkg::mode_t mode_reg, mode_next;
    logic [7:0]     value_reg, value_next;
    logic [1:0]     count_reg, count_next;

    logic [7:0] byte_reg [esd_pkg::MaxResults];
    logic       end_reg  [esd_pkg::MaxResults];
    logic [1:0] res_cnt_reg;
    logic [1:0] rd_idx_reg;

    logic [7:0] byte_next [esd_pkg::MaxResults];
    logic       end_next  [esd_pkg::MaxResults];
    logic [1:0] res_cnt_next;

    logic in_fire;
    logic out_fire;
    logic out_final;

    assign m_valid      = rd_idx_reg != res_cnt_reg;
    assign out_final    = (rd_idx_reg + 2'd1) == res_cnt_reg;
    assign s_ready      = !m_valid || (m_ready && out_final);
    assign in_fire      = s_valid && s_ready;
    assign out_fire     = m_valid && m_ready;
    assign m_out_byte   = byte_reg[rd_idx_reg];
    assign m_string_end = end_reg[rd_idx_reg];
    assign m_run_last   = out_final;

    always_comb begin
        esd_pkg::hex_digit_t hd;
        logic [7:0]          c;
        logic                is_oct;
        hd         = esd_pkg::hex_value(s_in_byte);
        c          = s_in_byte;
        is_oct     = c >= esd_pkg::CHAR_ZERO && c <= esd_pkg::CHAR_SEVEN;
        mode_next  = mode_reg;
        value_next = value_reg;
        count_next = count_reg;
        res_cnt_next = 2'd0;
        for (int i = 0; i < esd_pkg::MaxResults; i++) begin
            byte_next[i] = 8'd0;
            end_next[i]  = 1'b0;
        end

        unique case (mode_reg)
            esd_pkg::MODE_PLAIN: begin
                if (c == esd_pkg::CHAR_BACKSLASH) begin
                    mode_next = esd_pkg::MODE_ESC;
                end else begin
                    byte_next[res_cnt_next] = c;
                    res_cnt_next = res_cnt_next + 2'd1;
                end
            end
            esd_pkg::MODE_ESC: begin
                mode_next = esd_pkg::MODE_PLAIN;
                unique case (c)
                    esd_pkg::CHAR_A: begin
                        byte_next[0] = esd_pkg::CODE_BEL;
                        res_cnt_next = 2'd1;
                    end
                    esd_pkg::CHAR_B: begin
                        byte_next[0] = esd_pkg::CODE_BS;
                        res_cnt_next = 2'd1;
                    end
                    esd_pkg::CHAR_F: begin
                        byte_next[0] = esd_pkg::CODE_FF;
                        res_cnt_next = 2'd1;
                    end
                    esd_pkg::CHAR_N: begin
                        byte_next[0] = esd_pkg::CODE_LF;
                        res_cnt_next = 2'd1;
                    end
                    esd_pkg::CHAR_R: begin
                        byte_next[0] = esd_pkg::CODE_CR;
                        res_cnt_next = 2'd1;
                    end
                    esd_pkg::CHAR_T: begin
                        byte_next[0] = esd_pkg::CODE_HT;
                        res_cnt_next = 2'd1;
                    end
                    esd_pkg::CHAR_V: begin
                        byte_next[0] = esd_pkg::CODE_VT;
                        res_cnt_next = 2'd1;
                    end
                    esd_pkg::CHAR_X: begin
                        mode_next  = esd_pkg::MODE_HEX;
                        value_next = 8'd0;
                        count_next = 2'd0;
                    end
                    default: begin
                        if (is_oct) begin
                            mode_next  = esd_pkg::MODE_OCT;
                            value_next = c - esd_pkg::CHAR_ZERO;
                            count_next = 2'd1;
                        end else begin
                            byte_next[0] = c;
                            res_cnt_next = 2'd1;
                        end
                    end
                endcase
            end
            esd_pkg::MODE_HEX: begin
                if (hd.valid) begin
                    value_next = {value_reg[3:0], hd.value};
                    count_next = count_reg + 2'd1;
                    if (count_next >= 2'd2) begin
                        byte_next[0] = value_next;
                        res_cnt_next = 2'd1;
                        mode_next  = esd_pkg::MODE_PLAIN;
                        value_next = 8'd0;
                        count_next = 2'd0;
                    end
                end else begin
                    // flush: no digits yields a literal x
                    byte_next[0] = (count_reg == 2'd0) ? esd_pkg::CHAR_X : value_reg;
                    res_cnt_next = 2'd1;
                    mode_next  = esd_pkg::MODE_PLAIN;
                    value_next = 8'd0;
                    count_next = 2'd0;
                    if (c == esd_pkg::CHAR_BACKSLASH) begin
                        mode_next = esd_pkg::MODE_ESC;
                    end else begin
                        byte_next[1] = c;
                        res_cnt_next = 2'd2;
                    end
                end
            end
            esd_pkg::MODE_OCT: begin
                if (is_oct) begin
                    value_next = {value_reg[4:0], 3'd0} + (c - esd_pkg::CHAR_ZERO);
                    count_next = count_reg + 2'd1;
                    if (count_next == 2'd3 || count_next == 2'd0) begin
                        byte_next[0] = value_next;
                        res_cnt_next = 2'd1;
                        mode_next  = esd_pkg::MODE_PLAIN;
                        value_next = 8'd0;
                        count_next = 2'd0;
                    end
                end else begin
                    byte_next[0] = value_reg;
                    res_cnt_next = 2'd1;
                    mode_next  = esd_pkg::MODE_PLAIN;
                    value_next = 8'd0;
                    count_next = 2'd0;
                    if (c == esd_pkg::CHAR_BACKSLASH) begin
                        mode_next = esd_pkg::MODE_ESC;
                    end else begin
                        byte_next[1] = c;
                        res_cnt_next = 2'd2;
                    end
                end
            end
        endcase

        if (s_in_last) begin
            if (mode_next == esd_pkg::MODE_HEX || mode_next == esd_pkg::MODE_OCT) begin
                byte_next[res_cnt_next] = (mode_next == esd_pkg::MODE_HEX
                                           && count_next == 2'd0)
                                          ? esd_pkg::CHAR_X : value_next;
                res_cnt_next = res_cnt_next + 2'd1;
            end
            byte_next[res_cnt_next] = 8'd0;
            end_next[res_cnt_next]  = 1'b1;
            res_cnt_next = res_cnt_next + 2'd1;
            mode_next  = esd_pkg::MODE_PLAIN;
            value_next = 8'd0;
            count_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= esd_pkg::MODE_PLAIN;
            value_reg   <= 8'd0;
            count_reg   <= 2'd0;
            res_cnt_reg <= 2'd0;
            rd_idx_reg  <= 2'd0;
        end else if (in_fire) begin
            mode_reg    <= mode_next;
            value_reg   <= value_next;
            count_reg   <= count_next;
            res_cnt_reg <= res_cnt_next;
            rd_idx_reg  <= 2'd0;
        end else if (out_fire) begin
            rd_idx_reg  <= rd_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            for (int i = 0; i < esd_pkg::MaxResults; i++) begin
                byte_reg[i] <= byte_next[i];
                end_reg[i]  <= end_next[i];
            end
        end
    end

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_idx_reg <= res_cnt_reg)
        else $error("read index past result count");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        res_cnt_reg <= 2'd3)
        else $error("result count out of range");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && m_valid) |-> (m_ready && m_run_last))
        else $error("input taken while results still pending");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_in_last) |=> (mode_reg == esd_pkg::MODE_PLAIN && count_reg == 2'd0))
        else $error("state not cleared after end of string");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_in_last) |=> (m_valid && end_reg[res_cnt_reg - 2'd1]))
        else $error("end of string without terminator");

endmodule

### tb/sv/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit  = 4000;
    localparam int HoldCycles = 300;
    localparam int DrainPause = 10;

    typedef struct {
        logic [7:0]  ch;
        logic        last;
        int unsigned gap;
    } char_beat_t;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       str_end;
    } decoded_t;

    logic       aclk         = 1'b0;
    logic       aresetn      = 1'b0;
    logic       s_valid      = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte    = 8'h20;
    logic       s_in_last    = 1'b0;
    logic       m_valid;
    logic       m_ready      = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_run_last;
    logic       m_string_end;

    char_beat_t pending_chars[$];
    decoded_t   decoded_q[$];
    decoded_t   beat_out[$];
    logic [7:0] txt[$];

    esd_pkg::mode_t dec_mode  = esd_pkg::MODE_PLAIN;
    logic [7:0]     dec_value = 8'd0;
    logic [1:0]     dec_count = 2'd0;

    int beats_in   = 0;
    int total      = 0;
    int errors     = 0;
    int idle_count = 0;

    escape_sequence_decoder dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_in_last    (s_in_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_run_last   (m_run_last),
        .m_string_end (m_string_end)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // decoder prediction
    function automatic int hex_digit_of(input logic [7:0] c);
        if (c >= esd_pkg::CHAR_ZERO && c <= esd_pkg::CHAR_NINE) begin
            return int'(c - esd_pkg::CHAR_ZERO);
        end
        if (c >= esd_pkg::CHAR_LOWER_A && c <= esd_pkg::CHAR_LOWER_F) begin
            return int'(c - esd_pkg::CHAR_LOWER_A) + 10;
        end
        if (c >= esd_pkg::CHAR_UPPER_A && c <= esd_pkg::CHAR_UPPER_F) begin
            return int'(c - esd_pkg::CHAR_UPPER_A) + 10;
        end
        return -1;
    endfunction

    function automatic logic is_octal(input logic [7:0] c);
        return c >= esd_pkg::CHAR_ZERO && c <= esd_pkg::CHAR_SEVEN;
    endfunction

    function automatic void put_byte(input logic [7:0] b, input logic e);
        beat_out.push_back('{data: b, run_last: 1'b0, str_end: e});
    endfunction

    function automatic void take_plain(input logic [7:0] c);
        if (c == esd_pkg::CHAR_BACKSLASH) begin
            dec_mode = esd_pkg::MODE_ESC;
        end else begin
            put_byte(c, 1'b0);
        end
    endfunction

    function automatic void flush_number();
        if (dec_mode == esd_pkg::MODE_HEX && dec_count == 2'd0) begin
            put_byte(esd_pkg::CHAR_X, 1'b0);
        end else begin
            put_byte(dec_value, 1'b0);
        end
        dec_mode  = esd_pkg::MODE_PLAIN;
        dec_value = 8'd0;
        dec_count = 2'd0;
    endfunction

    function automatic void take_escaped(input logic [7:0] c);
        dec_mode = esd_pkg::MODE_PLAIN;
        case (c)
            esd_pkg::CHAR_A: put_byte(esd_pkg::CODE_BEL, 1'b0);
            esd_pkg::CHAR_B: put_byte(esd_pkg::CODE_BS, 1'b0);
            esd_pkg::CHAR_F: put_byte(esd_pkg::CODE_FF, 1'b0);
            esd_pkg::CHAR_N: put_byte(esd_pkg::CODE_LF, 1'b0);
            esd_pkg::CHAR_R: put_byte(esd_pkg::CODE_CR, 1'b0);
            esd_pkg::CHAR_T: put_byte(esd_pkg::CODE_HT, 1'b0);
            esd_pkg::CHAR_V: put_byte(esd_pkg::CODE_VT, 1'b0);
            esd_pkg::CHAR_X: begin
                dec_mode  = esd_pkg::MODE_HEX;
                dec_value = 8'd0;
                dec_count = 2'd0;
            end
            default: begin
                if (is_octal(c)) begin
                    dec_mode  = esd_pkg::MODE_OCT;
                    dec_value = c - esd_pkg::CHAR_ZERO;
                    dec_count = 2'd1;
                end else begin
                    put_byte(c, 1'b0);
                end
            end
        endcase
    endfunction

    function automatic void decode_beat(input logic [7:0] c, input logic last);
        int d;
        beat_out.delete();
        d = hex_digit_of(c);
        case (dec_mode)
            esd_pkg::MODE_PLAIN: take_plain(c);
            esd_pkg::MODE_ESC:   take_escaped(c);
            esd_pkg::MODE_HEX: begin
                if (d >= 0) begin
                    dec_value = {dec_value[3:0], 4'(d)};
                    dec_count = dec_count + 2'd1;
                    if (dec_count >= 2'd2) begin
                        flush_number();
                    end
                end else begin
                    flush_number();
                    take_plain(c);
                end
            end
            default: begin
                if (is_octal(c)) begin
                    dec_value = {dec_value[4:0], 3'(c - esd_pkg::CHAR_ZERO)};
                    dec_count = dec_count + 2'd1;
                    if (dec_count >= 2'd3) begin
                        flush_number();
                    end
                end else begin
                    flush_number();
                    take_plain(c);
                end
            end
        endcase
        if (last) begin
            if (dec_mode == esd_pkg::MODE_HEX || dec_mode == esd_pkg::MODE_OCT) begin
                flush_number();
            end
            put_byte(8'd0, 1'b1);
            dec_mode  = esd_pkg::MODE_PLAIN;
            dec_value = 8'd0;
            dec_count = 2'd0;
        end
        if (beat_out.size() > 0) begin
            beat_out[beat_out.size() - 1].run_last = 1'b1;
        end
        foreach (beat_out[i]) begin
            decoded_q.push_back(beat_out[i]);
        end
    endfunction

    // stimulus construction
    function automatic int unsigned pick_gap(input logic calm);
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 2);
        end else if (r < 97) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(15, 40);
    endfunction

    function automatic void commit_text(input logic calm);
        foreach (txt[i]) begin
            pending_chars.push_back('{ch: txt[i], last: (i == txt.size() - 1),
                                      gap: pick_gap(calm)});
        end
        txt.delete();
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            txt.push_back(s[i]);
        end
        commit_text(1'b0);
    endfunction

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) begin
            return esd_pkg::CHAR_ZERO + 8'(v);
        end
        if ($urandom_range(0, 1) == 1) begin
            return esd_pkg::CHAR_UPPER_A + 8'(v - 10);
        end
        return esd_pkg::CHAR_LOWER_A + 8'(v - 10);
    endfunction

    function automatic void add_token();
        int         kind;
        int         nd;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            do begin
                c = 8'($urandom_range(1, 255));
            end while (c == esd_pkg::CHAR_BACKSLASH);
            txt.push_back(c);
        end else if (kind < 45) begin
            txt.push_back(esd_pkg::CHAR_BACKSLASH);
            case ($urandom_range(0, 6))
                0: txt.push_back(esd_pkg::CHAR_A);
                1: txt.push_back(esd_pkg::CHAR_B);
                2: txt.push_back(esd_pkg::CHAR_F);
                3: txt.push_back(esd_pkg::CHAR_N);
                4: txt.push_back(esd_pkg::CHAR_R);
                5: txt.push_back(esd_pkg::CHAR_T);
                default: txt.push_back(esd_pkg::CHAR_V);
            endcase
        end else if (kind < 65) begin
            txt.push_back(esd_pkg::CHAR_BACKSLASH);
            txt.push_back(esd_pkg::CHAR_X);
            nd = $urandom_range(0, 2);
            for (int i = 0; i < nd; i++) begin
                txt.push_back(hex_char($urandom_range(0, 15)));
            end
        end else if (kind < 85) begin
            txt.push_back(esd_pkg::CHAR_BACKSLASH);
            nd = $urandom_range(1, 3);
            for (int i = 0; i < nd; i++) begin
                txt.push_back(esd_pkg::CHAR_ZERO + 8'($urandom_range(0, 7)));
            end
        end else if (kind < 95) begin
            txt.push_back(esd_pkg::CHAR_BACKSLASH);
            txt.push_back(8'($urandom_range(1, 255)));
        end else begin
            txt.push_back(hex_char($urandom_range(0, 15)));
        end
    endfunction

    initial begin
        int ntok;
        add_text("\\a\\b\\f\\n\\r\\t\\v");
        add_text("\\xfA\\x7\\xg\\777\\18\\");
        txt.push_back(8'hFF);
        txt.push_back(8'h01);
        commit_text(1'b0);
        while (pending_chars.size() < 430) begin
            ntok = $urandom_range(1, 5);
            for (int i = 0; i < ntok; i++) begin
                add_token();
            end
            if ($urandom_range(0, 19) == 0) begin
                txt.push_back(esd_pkg::CHAR_BACKSLASH);
            end
            commit_text($urandom_range(0, 3) == 0);
        end
        total = pending_chars.size();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        do begin
            @(negedge aclk);
        end while (beats_in < total || decoded_q.size() > 0);
        repeat (DrainPause) @(negedge aclk);

        if (errors == 0 && decoded_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // input driver
    always @(posedge aclk) begin : drive
        char_beat_t  nxt;
        int unsigned gap_left;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                decode_beat(s_in_byte, s_in_last);
                beats_in++;
            end
            if (s_valid && !s_ready) begin
                // hold the beat
            end else if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_chars.size() > 0) begin
                nxt = pending_chars.pop_front();
                s_valid   <= 1'b1;
                s_in_byte <= nxt.ch;
                s_in_last <= nxt.last;
                gap_left  = nxt.gap;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(posedge aclk) begin : receive
        int   stall_left;
        int   cyc;
        int   r;
        logic hold_done;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
            cyc        = 0;
            hold_done  = 1'b0;
        end else begin
            cyc++;
            if (!hold_done && beats_in >= 120) begin
                hold_done  = 1'b1;
                stall_left = HoldCycles;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (cyc % 256 >= 64) begin
                    r = $urandom_range(0, 99);
                    if (r < 15) begin
                        stall_left = $urandom_range(1, 3);
                    end else if (r < 18) begin
                        stall_left = $urandom_range(5, 20);
                    end else if (r == 18) begin
                        stall_left = $urandom_range(30, 60);
                    end
                end
            end
        end
    end

    // result checker
    always @(posedge aclk) begin : check
        decoded_t want;
        if (aresetn && m_valid && m_ready) begin
            if (decoded_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat: out_byte %02h run_last %b string_end %b",
                         $time, m_out_byte, m_run_last, m_string_end);
            end else begin
                want = decoded_q.pop_front();
                if (m_out_byte !== want.data) begin
                    errors++;
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want.data, m_out_byte);
                end
                if (m_run_last !== want.run_last) begin
                    errors++;
                    $display("%0t: run_last expected %b actual %b",
                             $time, want.run_last, m_run_last);
                end
                if (m_string_end !== want.str_end) begin
                    errors++;
                    $display("%0t: string_end expected %b actual %b",
                             $time, want.str_end, m_string_end);
                end
            end
        end
    end

    // stall watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_count = 0;
        end else begin
            idle_count++;
        end
        if (idle_count >= IdleLimit) begin
            $display("%0t: no beat moved for %0d cycles", $time, IdleLimit);
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
